/* rtl/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants of the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

   localparam int FRAC_BITS = 14;
   localparam int QUO_BITS  = 15;
   localparam int NUM_W     = 49;
   localparam int DEN_W     = 34;
   localparam int ELEMS     = 9;
   localparam logic [15:0] ONE_Q = 16'd16384;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic               zero_quat;
   } rsp_type;

   // Rounded division operands: num = 2|x| + n, den = 2n.
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
   } frac_type;

   typedef struct packed {
      logic [NUM_W-1:0]    rem;
      logic [DEN_W-1:0]    den;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
   } div_stage_type;

   typedef struct packed {
      logic [QUO_BITS-1:0] quo;
      logic                neg;
   } quo_type;

endpackage

/* rtl/quaternion_to_rotation_matrix_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Quaternion (Q2.14) to normalized 3x3 rotation matrix (Q2.14).
// ----------------------------------------------------------------------------
// Pipeline from request acceptance to rsp_valid: four front
// stages, fifteen restoring divider stages (one quotient bit each), then
// the output register.
// Throughput: one request per cycle when not stalled; every stage is its own register.
// A stall at the output holds the whole pipeline in place.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qrm_pkg::rsp_type  rsp_data
);
   import qrm_pkg::*;

   // front stages plus divider stages ahead of the output register
   localparam int DEPTH = 4 + QUO_BITS;

   logic             enable;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] zero_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   frac_type [8:0]   frac;
   quo_type          quo [9];
   logic [15:0]      elem [9];

   // advance everything unless a finished result is being held
   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   qrm_front u_front (
      .clock  (clock),
      .enable (enable),
      .quat   (req_data),
      .frac   (frac)
   );

   for (genvar i = 0; i < ELEMS; i++) begin : g_div
      qrm_div u_div (
         .clock  (clock),
         .enable (enable),
         .frac   (frac[i]),
         .quo    (quo[i])
      );
   end

   // round has been folded into the operands; saturate and apply sign
   always_comb begin
      logic [15:0] mag;
      for (int i = 0; i < ELEMS; i++) begin
         mag = (16'(quo[i].quo) > ONE_Q) ? ONE_Q : 16'(quo[i].quo);
         elem[i] = quo[i].neg ? 16'(-mag) : mag;
      end
      rsp_in.m00 = elem[0];
      rsp_in.m01 = elem[1];
      rsp_in.m02 = elem[2];
      rsp_in.m10 = elem[3];
      rsp_in.m11 = elem[4];
      rsp_in.m12 = elem[5];
      rsp_in.m20 = elem[6];
      rsp_in.m21 = elem[7];
      rsp_in.m22 = elem[8];
      rsp_in.zero_quat = zero_ff[DEPTH-1];
      // zero norm: drop the quotients and give the identity
      if (zero_ff[DEPTH-1]) begin
         rsp_in.m00 = ONE_Q;
         rsp_in.m01 = '0;
         rsp_in.m02 = '0;
         rsp_in.m10 = '0;
         rsp_in.m11 = ONE_Q;
         rsp_in.m12 = '0;
         rsp_in.m20 = '0;
         rsp_in.m21 = '0;
         rsp_in.m22 = ONE_Q;
      end
   end

   // valid and zero flags travel alongside the arithmetic stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= {valid_ff[DEPTH-2:0], req_valid};
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff <= {zero_ff[DEPTH-2:0], (req_data == '0)};
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // input is held back only while a result waits on a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held result");

   // a zero quaternion always leaves as the identity (diagonal, m01, m12, m20 checked)
   a_zero_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_quat) |->
         (rsp_data.m00 == ONE_Q && rsp_data.m11 == ONE_Q && rsp_data.m22 == ONE_Q
          && rsp_data.m01 == '0 && rsp_data.m12 == '0 && rsp_data.m20 == '0))
      else $error("zero quaternion did not give identity");

   // saturation keeps every element within plus or minus one; m00 and m12 are checked
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.m00) <= $signed(ONE_Q)
                  && $signed(rsp_data.m00) >= -$signed(ONE_Q)
                  && $signed(rsp_data.m12) <= $signed(ONE_Q)
                  && $signed(rsp_data.m12) >= -$signed(ONE_Q)))
      else $error("matrix element out of range");

endmodule

/* rtl/qrm_front.sv */
// ----------------------------------------------------------------------------
// qrm_front
// Products, norm and numerator magnitudes, four register stages.
// ----------------------------------------------------------------------------
module qrm_front (
   input  logic                     clock,
   input  logic                     enable,
   input  qrm_pkg::req_type         quat,
   output qrm_pkg::frac_type [8:0]  frac
);
   import qrm_pkg::*;

   // stage 1: products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] xy_ff, xz_ff, yz_ff, xw_ff, yw_ff, zw_ff;
   // stage 2: sums
   logic [32:0] n2_ff;
   logic [31:0] syz_ff, sxz_ff, sxy_ff;
   logic signed [32:0] off_ff [6];
   // stage 3: magnitudes
   logic [32:0] n3_ff;
   logic [47:0] mag_ff [9];
   logic        neg_ff [9];
   // stage 4: divider operands
   frac_type [8:0] frac_ff;

   logic signed [34:0] diag_in [3];
   logic [32:0]        dmag_in [3];
   logic [32:0]        omag_in [6];

   always_comb begin
      diag_in[0] = $signed({2'b00, n2_ff}) - $signed({2'b00, syz_ff, 1'b0});
      diag_in[1] = $signed({2'b00, n2_ff}) - $signed({2'b00, sxz_ff, 1'b0});
      diag_in[2] = $signed({2'b00, n2_ff}) - $signed({2'b00, sxy_ff, 1'b0});
      for (int i = 0; i < 3; i++) begin
         dmag_in[i] = diag_in[i][34] ? 33'(-diag_in[i]) : diag_in[i][32:0];
      end
      for (int i = 0; i < 6; i++) begin
         omag_in[i] = off_ff[i][32] ? 33'(-off_ff[i]) : 33'(off_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ww_ff <= quat.quat_w * quat.quat_w;
         xx_ff <= quat.quat_x * quat.quat_x;
         yy_ff <= quat.quat_y * quat.quat_y;
         zz_ff <= quat.quat_z * quat.quat_z;
         xy_ff <= quat.quat_x * quat.quat_y;
         xz_ff <= quat.quat_x * quat.quat_z;
         yz_ff <= quat.quat_y * quat.quat_z;
         xw_ff <= quat.quat_x * quat.quat_w;
         yw_ff <= quat.quat_y * quat.quat_w;
         zw_ff <= quat.quat_z * quat.quat_w;

         n2_ff  <= 33'(ww_ff[30:0]) + 33'(xx_ff[30:0]) + 33'(yy_ff[30:0])
                   + 33'(zz_ff[30:0]);
         syz_ff <= 32'(yy_ff[30:0]) + 32'(zz_ff[30:0]);
         sxz_ff <= 32'(xx_ff[30:0]) + 32'(zz_ff[30:0]);
         sxy_ff <= 32'(xx_ff[30:0]) + 32'(yy_ff[30:0]);
         // order: m01, m02, m10, m12, m20, m21
         off_ff[0] <= 33'(xy_ff) - 33'(zw_ff);
         off_ff[1] <= 33'(xz_ff) + 33'(yw_ff);
         off_ff[2] <= 33'(xy_ff) + 33'(zw_ff);
         off_ff[3] <= 33'(yz_ff) - 33'(xw_ff);
         off_ff[4] <= 33'(xz_ff) - 33'(yw_ff);
         off_ff[5] <= 33'(yz_ff) + 33'(xw_ff);

         n3_ff <= n2_ff;
         mag_ff[0] <= {1'b0, dmag_in[0], 14'b0};
         mag_ff[4] <= {1'b0, dmag_in[1], 14'b0};
         mag_ff[8] <= {1'b0, dmag_in[2], 14'b0};
         neg_ff[0] <= diag_in[0][34];
         neg_ff[4] <= diag_in[1][34];
         neg_ff[8] <= diag_in[2][34];
         mag_ff[1] <= {omag_in[0], 15'b0};
         mag_ff[2] <= {omag_in[1], 15'b0};
         mag_ff[3] <= {omag_in[2], 15'b0};
         mag_ff[5] <= {omag_in[3], 15'b0};
         mag_ff[6] <= {omag_in[4], 15'b0};
         mag_ff[7] <= {omag_in[5], 15'b0};
         neg_ff[1] <= off_ff[0][32];
         neg_ff[2] <= off_ff[1][32];
         neg_ff[3] <= off_ff[2][32];
         neg_ff[5] <= off_ff[3][32];
         neg_ff[6] <= off_ff[4][32];
         neg_ff[7] <= off_ff[5][32];

         for (int i = 0; i < ELEMS; i++) begin
            frac_ff[i].num <= {mag_ff[i], 1'b0} + NUM_W'(n3_ff);
            frac_ff[i].den <= {n3_ff, 1'b0};
            frac_ff[i].neg <= neg_ff[i];
         end
      end
   end

   assign frac = frac_ff;

endmodule

/* rtl/qrm_div.sv */
// ----------------------------------------------------------------------------
// qrm_div
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qrm_div (
   input  logic               clock,
   input  logic               enable,
   input  qrm_pkg::frac_type  frac,
   output qrm_pkg::quo_type   quo
);
   import qrm_pkg::*;

   div_stage_type stage_ff [QUO_BITS];

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      localparam int BIT = QUO_BITS - 1 - k;
      div_stage_type cur;
      div_stage_type nxt_in;
      logic [NUM_W-1:0] trial;

      always_comb begin
         if (k == 0) begin
            cur.rem = frac.num;
            cur.den = frac.den;
            cur.quo = '0;
            cur.neg = frac.neg;
         end else begin
            cur = stage_ff[(k == 0) ? 0 : k - 1];
         end
         trial  = NUM_W'(cur.den) << BIT;
         nxt_in = cur;
         if (cur.rem >= trial) begin
            nxt_in.rem      = cur.rem - trial;
            nxt_in.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            stage_ff[k] <= nxt_in;
         end
      end
   end

   assign quo.quo = stage_ff[QUO_BITS-1].quo;
   assign quo.neg = stage_ff[QUO_BITS-1].neg;

endmodule
